// File: hdl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types and fixed constants of the PID controller with ramp limit.
// ----------------------------------------------------------------------------
package prl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int K_W       = 20;
    localparam int DT_W      = 19;
    localparam int DVW       = 37;

    localparam logic [19:0]      DT_MAX     = 20'd500000;
    localparam logic [DT_W-1:0]  DT_DEFAULT = 19'd1000;

    localparam logic [K_W-1:0]   K_ONE      = 20'd1;
    localparam logic [K_W-1:0]   K_MICRO    = 20'd1000000;

    localparam logic [DVW-1:0]   DV_FRAC    = 37'd65536;
    localparam logic [DVW-1:0]   HV_FRAC    = 37'd32768;
    localparam logic [DVW-1:0]   DV_INTEG   = 37'd131072000000;
    localparam logic [DVW-1:0]   HV_INTEG   = 37'd65536000000;
    localparam logic [DVW-1:0]   DV_MICRO   = 37'd1000000;
    localparam logic [DVW-1:0]   HV_MICRO   = 37'd500000;

    typedef enum logic [2:0] {
        REG_P_GAIN       = 3'd0,
        REG_I_GAIN       = 3'd1,
        REG_D_GAIN       = 3'd2,
        REG_RAMP_RATE    = 3'd3,
        REG_OUTPUT_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic shl;
        logic sub;
    } alu_op_t;

    typedef struct packed {
        logic start;
        logic neg;
    } md_ctrl_t;

endpackage

// File: hdl/prl_alu.sv
// ----------------------------------------------------------------------------
// prl_alu
// Shared adder and subtractor with an optional left shift of the first operand.
// ----------------------------------------------------------------------------
module prl_alu #(
    parameter int AW = 84
) (
    input  logic              [AW-1:0] x,
    input  prl_pkg::alu_op_t           op,
    input  logic              [AW-1:0] y,
    output logic              [AW-1:0] sum,
    output logic                       cout
);

    logic [AW-1:0] xs;
    logic [AW-1:0] ys;

    always_comb
    begin
        xs = op.shl ? {x[AW-2:0], 1'b0} : x;
        ys = op.sub ? ~y : y;
        {cout, sum} = {1'b0, xs} + {1'b0, ys} + {{AW{1'b0}}, op.sub};
    end

endmodule

// File: hdl/prl_muldiv.sv
// ----------------------------------------------------------------------------
// prl_muldiv
// Sequencer that forms round(a * b * k / d) with ties away from zero and
// saturates the signed result, using the shared adder one bit per cycle.
// ----------------------------------------------------------------------------
module prl_muldiv #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  prl_pkg::md_ctrl_t                ctrl,
    input  logic [VALUE_WIDTH-1:0]           a_mag,
    input  logic [VALUE_WIDTH:0]             b_mag,
    input  logic [prl_pkg::K_W-1:0]          k_val,
    input  logic [prl_pkg::DVW-1:0]          dvs,
    input  logic [prl_pkg::DVW-1:0]          half,
    output logic                             done,
    output logic signed [VALUE_WIDTH-1:0]    result
);

    import prl_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int NW    = (2*W + 20 > W + DVW + 1) ? 2*W + 20 : W + DVW + 1;
    localparam int CNT_N = (W + 1 > K_W) ? W + 1 : K_W;
    localparam int CW    = $clog2(CNT_N);

    typedef enum logic [6:0] {
        MD_IDLE = 7'b0000001,
        MD_MUL1 = 7'b0000010,
        MD_MUL2 = 7'b0000100,
        MD_HALF = 7'b0001000,
        MD_OVF  = 7'b0010000,
        MD_DIV  = 7'b0100000,
        MD_DONE = 7'b1000000
    } md_state_t;

    md_state_t       state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   acc_reg, acc_next;
    logic [NW-1:0]   mcand_reg, mcand_next;
    logic [W:0]      mplr_reg, mplr_next;
    logic [K_W-1:0]  k_reg, k_next;
    logic [DVW-1:0]  dvs_reg, dvs_next;
    logic [DVW-1:0]  half_reg, half_next;
    logic            neg_reg, neg_next;
    logic            ovf_reg, ovf_next;

    alu_op_t         op;
    logic [NW-1:0]   y_sel;
    logic [NW-1:0]   sum;
    logic            cout;
    logic [W-1:0]    q;
    logic            big_pos;
    logic            big_neg;

    prl_alu #(
        .AW (NW)
    ) u_alu (
        .x    (acc_reg),
        .op   (op),
        .y    (y_sel),
        .sum  (sum),
        .cout (cout)
    );

    always_comb
    begin
        op    = '0;
        y_sel = '0;
        case (state_reg)
            MD_MUL1:
            begin
                op.shl = 1'b1;
                y_sel  = mplr_reg[W] ? mcand_reg : '0;
            end
            MD_MUL2:
            begin
                op.shl = 1'b1;
                y_sel  = k_reg[K_W-1] ? mcand_reg : '0;
            end
            MD_HALF:
            begin
                y_sel = NW'(half_reg);
            end
            MD_OVF:
            begin
                op.sub = 1'b1;
                y_sel  = NW'(dvs_reg) << W;
            end
            MD_DIV:
            begin
                op.shl = 1'b1;
                op.sub = 1'b1;
                y_sel  = NW'(dvs_reg) << W;
            end
            default:
            begin
                y_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        k_next     = k_reg;
        dvs_next   = dvs_reg;
        half_next  = half_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (ctrl.start)
                begin
                    acc_next   = '0;
                    mcand_next = NW'(a_mag);
                    mplr_next  = b_mag;
                    k_next     = k_val;
                    dvs_next   = dvs;
                    half_next  = half;
                    neg_next   = ctrl.neg;
                    ovf_next   = 1'b0;
                    cnt_next   = CW'(W);
                    state_next = MD_MUL1;
                end
            end
            MD_MUL1:
            begin
                acc_next  = sum;
                mplr_next = {mplr_reg[W-1:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    mcand_next = sum;
                    acc_next   = '0;
                    cnt_next   = CW'(K_W - 1);
                    state_next = MD_MUL2;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_MUL2:
            begin
                acc_next = sum;
                k_next   = {k_reg[K_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = MD_HALF;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_HALF:
            begin
                acc_next   = sum;
                state_next = MD_OVF;
            end
            MD_OVF:
            begin
                if (cout)
                begin
                    ovf_next   = 1'b1;
                    state_next = MD_DONE;
                end
                else
                begin
                    cnt_next   = CW'(W - 1);
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                acc_next = cout ? {sum[NW-1:1], 1'b1} : {acc_reg[NW-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = MD_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        k_reg     <= k_next;
        dvs_reg   <= dvs_next;
        half_reg  <= half_next;
    end

    always_comb
    begin
        q       = acc_reg[W-1:0];
        big_pos = ovf_reg || q[W-1];
        big_neg = ovf_reg || (q[W-1] && (|q[W-2:0]));
        if (neg_reg)
        begin
            result = big_neg ? {1'b1, {(W-1){1'b0}}} : (~q + 1'b1);
        end
        else
        begin
            result = big_pos ? {1'b0, {(W-1){1'b1}}} : q;
        end
    end

    assign done = (state_reg == MD_DONE);

endmodule

// File: hdl/prl_cfg.sv
// ----------------------------------------------------------------------------
// prl_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module prl_cfg #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [((VALUE_WIDTH > 32) ? 6 : 5)-1:0]     paddr,
    input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
    output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]   prdata,
    output logic                                        pready,
    output logic signed [VALUE_WIDTH-1:0]               p_gain,
    output logic signed [VALUE_WIDTH-1:0]               i_gain,
    output logic signed [VALUE_WIDTH-1:0]               d_gain,
    output logic        [VALUE_WIDTH-2:0]               ramp_rate,
    output logic        [VALUE_WIDTH-2:0]               output_limit
);

    import prl_pkg::*;

    localparam int W       = VALUE_WIDTH;
    localparam int DATA_W  = (W > 32) ? 64 : 32;
    localparam int ADDR_W  = (W > 32) ? 6 : 5;
    localparam int IDX_LSB = (W > 32) ? 3 : 2;

    logic signed [W-1:0] p_gain_reg;
    logic signed [W-1:0] i_gain_reg;
    logic signed [W-1:0] d_gain_reg;
    logic        [W-2:0] ramp_rate_reg;
    logic        [W-2:0] output_limit_reg;
    cfg_idx_t            idx;
    logic                wr_en;

    assign idx    = cfg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg       <= '0;
            i_gain_reg       <= '0;
            d_gain_reg       <= '0;
            ramp_rate_reg    <= '0;
            output_limit_reg <= '1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_P_GAIN:       p_gain_reg       <= pwdata[W-1:0];
                REG_I_GAIN:       i_gain_reg       <= pwdata[W-1:0];
                REG_D_GAIN:       d_gain_reg       <= pwdata[W-1:0];
                REG_RAMP_RATE:    ramp_rate_reg    <= pwdata[W-2:0];
                REG_OUTPUT_LIMIT: output_limit_reg <= pwdata[W-2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_P_GAIN:       prdata = DATA_W'(p_gain_reg);
            REG_I_GAIN:       prdata = DATA_W'(i_gain_reg);
            REG_D_GAIN:       prdata = DATA_W'(d_gain_reg);
            REG_RAMP_RATE:    prdata = DATA_W'(ramp_rate_reg);
            REG_OUTPUT_LIMIT: prdata = DATA_W'(output_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign p_gain       = p_gain_reg;
    assign i_gain       = i_gain_reg;
    assign d_gain       = d_gain_reg;
    assign ramp_rate    = ramp_rate_reg;
    assign output_limit = output_limit_reg;

endmodule

// File: hdl/pid_with_ramp_limit_unit.sv
// ----------------------------------------------------------------------------
// pid_with_ramp_limit_unit
// An update request runs four multiply-divide passes on the shared adder,
// a shorter pass when a product saturates, then the mix states, and delivers
// its result from the finish state; the next request is taken back in idle.
// A clear request goes straight to the finish state for its zero result.
// Reset is asynchronous and active low; it clears the loop state and the
// registers, with the output limit at its largest value.
// ----------------------------------------------------------------------------
module pid_with_ramp_limit_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 20
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [((VALUE_WIDTH > 32) ? 6 : 5)-1:0]     paddr,
    input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
    output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]   prdata,
    output logic                                        pready,
    input  logic                                        req_valid,
    output logic                                        req_stall,
    input  logic                                        cmd,
    input  logic signed [VALUE_WIDTH-1:0]               error_value,
    input  logic        [TIME_WIDTH-1:0]                elapsed_us,
    output logic                                        drive_valid,
    input  logic                                        drive_stall,
    output logic signed [VALUE_WIDTH-1:0]               drive_value
);

    import prl_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int EW = (TIME_WIDTH > 20) ? TIME_WIDTH : 20;

    typedef enum logic [9:0] {
        T_IDLE  = 10'b0000000001,
        T_PROP  = 10'b0000000010,
        T_INTEG = 10'b0000000100,
        T_DERIV = 10'b0000001000,
        T_STEP  = 10'b0000010000,
        T_MIX_I = 10'b0000100000,
        T_MIX_O = 10'b0001000000,
        T_MIX_R = 10'b0010000000,
        T_MIX_C = 10'b0100000000,
        T_FIN   = 10'b1000000000
    } top_state_t;

    logic signed [W-1:0] p_gain;
    logic signed [W-1:0] i_gain;
    logic signed [W-1:0] d_gain;
    logic        [W-2:0] ramp_rate;
    logic        [W-2:0] output_limit;

    top_state_t          state_reg, state_next;
    logic                issued_reg, issued_next;
    logic                cmd_reg, cmd_next;
    logic                drive_valid_reg, drive_valid_next;
    logic signed [W-1:0] isum_reg, isum_next;
    logic signed [W-1:0] lerr_reg, lerr_next;
    logic signed [W-1:0] lout_reg, lout_next;

    logic signed [W-1:0] err_reg, err_next;
    logic [DT_W-1:0]     dt_reg, dt_next;
    logic signed [W-1:0] prop_reg, prop_next;
    logic signed [W-1:0] di_reg, di_next;
    logic signed [W-1:0] deriv_reg, deriv_next;
    logic signed [W-1:0] stp_reg, stp_next;
    logic signed [W-1:0] integ_reg, integ_next;
    logic signed [W-1:0] outv_reg, outv_next;
    logic signed [W:0]   cand_reg, cand_next;
    logic signed [W-1:0] drive_value_reg, drive_value_next;

    logic [EW-1:0]       el_ext;
    logic [DT_W-1:0]     dt_eff;
    logic signed [W:0]   sum_e;
    logic signed [W:0]   dif_e;
    logic [W-1:0]        mag_p;
    logic [W-1:0]        mag_i;
    logic [W-1:0]        mag_d;
    logic [W-1:0]        mag_e;
    logic [W:0]          mag_sum;
    logic [W:0]          mag_dif;

    logic signed [W:0]   lim1;
    logic signed [W:0]   nlim1;
    logic signed [W:0]   clamp_in;
    logic signed [W:0]   clamp_out;
    logic signed [W+1:0] lim2;
    logic signed [W+1:0] nlim2;
    logic signed [W+1:0] sum3;
    logic signed [W:0]   ov_ext;
    logic signed [W:0]   up_ext;
    logic signed [W:0]   dn_ext;

    logic                job_st;
    md_ctrl_t            md_ctrl;
    logic [W-1:0]        md_a;
    logic [W:0]          md_b;
    logic [K_W-1:0]      md_k;
    logic [DVW-1:0]      md_dv;
    logic [DVW-1:0]      md_hv;
    logic                md_done;
    logic signed [W-1:0] md_result;

    prl_cfg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .p_gain       (p_gain),
        .i_gain       (i_gain),
        .d_gain       (d_gain),
        .ramp_rate    (ramp_rate),
        .output_limit (output_limit)
    );

    prl_muldiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .a_mag  (md_a),
        .b_mag  (md_b),
        .k_val  (md_k),
        .dvs    (md_dv),
        .half   (md_hv),
        .done   (md_done),
        .result (md_result)
    );

    // An elapsed time of zero or beyond the maximum falls back to the default.
    always_comb
    begin
        el_ext = EW'(elapsed_us);
        if ((el_ext == '0) || (el_ext > EW'(DT_MAX)))
        begin
            dt_eff = DT_DEFAULT;
        end
        else
        begin
            dt_eff = el_ext[DT_W-1:0];
        end
    end

    always_comb
    begin
        sum_e   = {err_reg[W-1], err_reg} + {lerr_reg[W-1], lerr_reg};
        dif_e   = {err_reg[W-1], err_reg} - {lerr_reg[W-1], lerr_reg};
        mag_p   = p_gain[W-1] ? (~p_gain + 1'b1) : p_gain;
        mag_i   = i_gain[W-1] ? (~i_gain + 1'b1) : i_gain;
        mag_d   = d_gain[W-1] ? (~d_gain + 1'b1) : d_gain;
        mag_e   = err_reg[W-1] ? (~err_reg + 1'b1) : err_reg;
        mag_sum = sum_e[W] ? (~sum_e + 1'b1) : sum_e;
        mag_dif = dif_e[W] ? (~dif_e + 1'b1) : dif_e;
    end

    assign job_st = state_reg inside {T_PROP, T_INTEG, T_DERIV, T_STEP};

    always_comb
    begin
        md_ctrl.start = job_st && !issued_reg;
        md_ctrl.neg   = 1'b0;
        md_a          = '0;
        md_b          = '0;
        md_k          = K_ONE;
        md_dv         = DV_FRAC;
        md_hv         = HV_FRAC;
        case (state_reg)
            T_PROP:
            begin
                md_ctrl.neg = p_gain[W-1] ^ err_reg[W-1];
                md_a        = mag_p;
                md_b        = {1'b0, mag_e};
            end
            T_INTEG:
            begin
                md_ctrl.neg = i_gain[W-1] ^ sum_e[W];
                md_a        = mag_i;
                md_b        = mag_sum;
                md_k        = K_W'(dt_reg);
                md_dv       = DV_INTEG;
                md_hv       = HV_INTEG;
            end
            T_DERIV:
            begin
                md_ctrl.neg = d_gain[W-1] ^ dif_e[W];
                md_a        = mag_d;
                md_b        = mag_dif;
                md_k        = K_MICRO;
                md_dv       = DVW'(dt_reg) << FRAC_BITS;
                md_hv       = DVW'(dt_reg) << (FRAC_BITS - 1);
            end
            T_STEP:
            begin
                md_a  = {1'b0, ramp_rate};
                md_b  = (W+1)'(1);
                md_k  = K_W'(dt_reg);
                md_dv = DV_MICRO;
                md_hv = HV_MICRO;
            end
            default:
            begin
                md_a = '0;
            end
        endcase
    end

    // Clamping to the limit also covers saturation, since the limit never
    // exceeds the largest signed value.
    always_comb
    begin
        lim1     = {2'b00, output_limit};
        nlim1    = -lim1;
        lim2     = {3'b000, output_limit};
        nlim2    = -lim2;
        clamp_in = (state_reg == T_MIX_I)
                   ? ({isum_reg[W-1], isum_reg} + {di_reg[W-1], di_reg})
                   : cand_reg;
        if (clamp_in > lim1)
        begin
            clamp_out = lim1;
        end
        else if (clamp_in < nlim1)
        begin
            clamp_out = nlim1;
        end
        else
        begin
            clamp_out = clamp_in;
        end
        sum3   = {{2{prop_reg[W-1]}}, prop_reg} + {{2{integ_reg[W-1]}}, integ_reg}
               + {{2{deriv_reg[W-1]}}, deriv_reg};
        ov_ext = {outv_reg[W-1], outv_reg};
        up_ext = {lout_reg[W-1], lout_reg} + {stp_reg[W-1], stp_reg};
        dn_ext = {lout_reg[W-1], lout_reg} - {stp_reg[W-1], stp_reg};
    end

    always_comb
    begin
        state_next       = state_reg;
        issued_next      = issued_reg;
        cmd_next         = cmd_reg;
        drive_valid_next = drive_valid_reg && drive_stall;
        isum_next        = isum_reg;
        lerr_next        = lerr_reg;
        lout_next        = lout_reg;
        err_next         = err_reg;
        dt_next          = dt_reg;
        prop_next        = prop_reg;
        di_next          = di_reg;
        deriv_next       = deriv_reg;
        stp_next         = stp_reg;
        integ_next       = integ_reg;
        outv_next        = outv_reg;
        cand_next        = cand_reg;
        drive_value_next = drive_value_reg;

        if (md_ctrl.start)
        begin
            issued_next = 1'b1;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = cmd;
                    err_next   = error_value;
                    dt_next    = dt_eff;
                    state_next = cmd ? T_FIN : T_PROP;
                end
            end
            T_PROP:
            begin
                if (md_done)
                begin
                    prop_next   = md_result;
                    issued_next = 1'b0;
                    state_next  = T_INTEG;
                end
            end
            T_INTEG:
            begin
                if (md_done)
                begin
                    di_next     = md_result;
                    issued_next = 1'b0;
                    state_next  = T_DERIV;
                end
            end
            T_DERIV:
            begin
                if (md_done)
                begin
                    deriv_next  = md_result;
                    issued_next = 1'b0;
                    state_next  = T_STEP;
                end
            end
            T_STEP:
            begin
                if (md_done)
                begin
                    stp_next    = md_result;
                    issued_next = 1'b0;
                    state_next  = T_MIX_I;
                end
            end
            T_MIX_I:
            begin
                integ_next = clamp_out[W-1:0];
                state_next = T_MIX_O;
            end
            T_MIX_O:
            begin
                if (sum3 > lim2)
                begin
                    outv_next = lim2[W-1:0];
                end
                else if (sum3 < nlim2)
                begin
                    outv_next = nlim2[W-1:0];
                end
                else
                begin
                    outv_next = sum3[W-1:0];
                end
                state_next = T_MIX_R;
            end
            T_MIX_R:
            begin
                if ((ramp_rate != '0) && (ov_ext > up_ext))
                begin
                    cand_next = up_ext;
                end
                else if ((ramp_rate != '0) && (ov_ext < dn_ext))
                begin
                    cand_next = dn_ext;
                end
                else
                begin
                    cand_next = ov_ext;
                end
                state_next = T_MIX_C;
            end
            T_MIX_C:
            begin
                outv_next  = clamp_out[W-1:0];
                state_next = T_FIN;
            end
            T_FIN:
            begin
                if (!drive_valid_reg || !drive_stall)
                begin
                    drive_valid_next = 1'b1;
                    if (cmd_reg)
                    begin
                        drive_value_next = '0;
                        isum_next        = '0;
                        lerr_next        = '0;
                        lout_next        = '0;
                    end
                    else
                    begin
                        drive_value_next = outv_reg;
                        isum_next        = integ_reg;
                        lerr_next        = err_reg;
                        lout_next        = outv_reg;
                    end
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            issued_reg      <= 1'b0;
            cmd_reg         <= 1'b0;
            drive_valid_reg <= 1'b0;
            isum_reg        <= '0;
            lerr_reg        <= '0;
            lout_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            issued_reg      <= issued_next;
            cmd_reg         <= cmd_next;
            drive_valid_reg <= drive_valid_next;
            isum_reg        <= isum_next;
            lerr_reg        <= lerr_next;
            lout_reg        <= lout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg         <= err_next;
        dt_reg          <= dt_next;
        prop_reg        <= prop_next;
        di_reg          <= di_next;
        deriv_reg       <= deriv_next;
        stp_reg         <= stp_next;
        integ_reg       <= integ_next;
        outv_reg        <= outv_next;
        cand_reg        <= cand_next;
        drive_value_reg <= drive_value_next;
    end

    assign req_stall   = (state_reg != T_IDLE);
    assign drive_valid = drive_valid_reg;
    assign drive_value = drive_value_reg;

endmodule

// File: tb/prl_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prl_drive_checker
// Watches the register port and the request and result channels of the PID
// controller, keeps its own copy of the gains, limits and loop state, predicts
// every drive value from the accepted requests and compares it with the value
// the block delivers. Register reads are compared with the tracked contents.
// ----------------------------------------------------------------------------
module prl_drive_checker
    import prl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        cmd,
    input  logic [31:0] error_value,
    input  logic [19:0] elapsed_us,
    input  logic        drive_valid,
    input  logic        drive_stall,
    input  logic [31:0] drive_value,
    output int          fail_count,
    output int          pending
);

    localparam longint VAL_MAX = 64'sh7FFF_FFFF;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    longint kp, ki, kd, ramp_cfg, lim_cfg;
    longint integ_acc, prev_err, prev_drive;
    logic [31:0] drive_expect_q[$];

    function automatic longint unsigned mag64(longint v);
        if (v < 0)
            return -v;
        return v;
    endfunction

    // Exact a*b*k/d, rounded half away from zero, saturated to 32 bits signed.
    function automatic longint scale_round(longint a, longint b, longint unsigned k,
                                           longint unsigned d);
        logic [127:0] prod;
        logic [127:0] q;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        prod = 128'(mag64(a)) * 128'(mag64(b));
        prod = prod * 128'(k) + 128'(d >> 1);
        q    = prod / 128'(d);
        if (neg) begin
            if (q > 128'(VAL_MAX) + 128'd1)
                return VAL_MIN;
            return -longint'(q[63:0]);
        end
        if (q > 128'(VAL_MAX))
            return VAL_MAX;
        return longint'(q[63:0]);
    endfunction

    function automatic longint saturate(longint v);
        if (v > VAL_MAX)
            return VAL_MAX;
        if (v < VAL_MIN)
            return VAL_MIN;
        return v;
    endfunction

    function automatic longint clamp_sym(longint v, longint l);
        if (v > l)
            return l;
        if (v < -l)
            return -l;
        return v;
    endfunction

    function automatic logic [31:0] predict_drive(logic c, logic [31:0] ev, logic [19:0] t);
        longint          err, prop, integ, deriv, outv, stp, delta;
        longint unsigned dt;
        if (c) begin
            integ_acc  = 0;
            prev_err   = 0;
            prev_drive = 0;
            return '0;
        end
        err = longint'($signed(ev));
        dt  = 64'(t);
        if (dt == 0 || dt > DT_MAX)
            dt = 64'(DT_DEFAULT);
        prop  = scale_round(kp, err, 64'd1, 64'd65536);
        integ = scale_round(ki, err + prev_err, dt, 64'd131072000000);
        integ = clamp_sym(saturate(integ_acc + integ), lim_cfg);
        deriv = scale_round(kd, err - prev_err, 64'd1000000, dt * 64'd65536);
        outv  = clamp_sym(prop + integ + deriv, lim_cfg);
        if (ramp_cfg > 0) begin
            stp   = scale_round(ramp_cfg, longint'(dt), 64'd1, 64'd1000000);
            delta = outv - prev_drive;
            if (delta > stp)
                outv = prev_drive + stp;
            else if (delta < -stp)
                outv = prev_drive - stp;
            outv = clamp_sym(outv, lim_cfg);
        end
        integ_acc  = integ;
        prev_drive = outv;
        prev_err   = err;
        return outv[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [31:0] reg_view;
        logic [31:0] want;
        if (!rst_n) begin
            kp         = 0;
            ki         = 0;
            kd         = 0;
            ramp_cfg   = 0;
            lim_cfg    = VAL_MAX;
            integ_acc  = 0;
            prev_err   = 0;
            prev_drive = 0;
            drive_expect_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[4:2])
                        REG_P_GAIN:       kp = longint'($signed(pwdata));
                        REG_I_GAIN:       ki = longint'($signed(pwdata));
                        REG_D_GAIN:       kd = longint'($signed(pwdata));
                        REG_RAMP_RATE:    ramp_cfg = longint'(pwdata[30:0]);
                        REG_OUTPUT_LIMIT: lim_cfg = longint'(pwdata[30:0]);
                        default: ;
                    endcase
                end
                else if (paddr[4:2] <= REG_OUTPUT_LIMIT) begin
                    case (paddr[4:2])
                        REG_P_GAIN:    reg_view = kp[31:0];
                        REG_I_GAIN:    reg_view = ki[31:0];
                        REG_D_GAIN:    reg_view = kd[31:0];
                        REG_RAMP_RATE: reg_view = ramp_cfg[31:0];
                        default:       reg_view = lim_cfg[31:0];
                    endcase
                    if (prdata !== reg_view) begin
                        $display("%0t: read of register %0d: expected %h, actual %h",
                                 $time, paddr[4:2], reg_view, prdata);
                        fail_count++;
                    end
                end
            end
            if (drive_valid && !drive_stall) begin
                if (drive_expect_q.size() == 0) begin
                    $display("%0t: drive_value %h arrived with no request outstanding",
                             $time, drive_value);
                    fail_count++;
                end
                else begin
                    want = drive_expect_q.pop_front();
                    if (drive_value !== want) begin
                        $display("%0t: drive_value mismatch: expected %h (%0d), actual %h (%0d)",
                                 $time, want, $signed(want), drive_value,
                                 $signed(drive_value));
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                drive_expect_q.push_back(predict_drive(cmd, error_value, elapsed_us));
            pending = drive_expect_q.size();
        end
    end

endmodule

// File: tb/pid_with_ramp_limit_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_with_ramp_limit_unit_tb
// Drives the PID controller with directed corner requests and then with
// phases of random updates and clears under changing register settings and
// handshake pressure. A checker beside the block predicts and compares the
// results; this module only produces stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module pid_with_ramp_limit_unit_tb;
    import prl_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 1500;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_stall;
    logic        cmd;
    logic [31:0] error_value;
    logic [19:0] elapsed_us;
    logic        drive_valid;
    logic        drive_stall;
    logic [31:0] drive_value;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int cycle_cnt;
    logic hold_arm;
    logic hold_used;

    pid_with_ramp_limit_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .error_value (error_value),
        .elapsed_us  (elapsed_us),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_value (drive_value)
    );

    prl_drive_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .error_value (error_value),
        .elapsed_us  (elapsed_us),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_value (drive_value),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that backs up the block.
    initial
    begin
        drive_stall = 1'b0;
        hold_left   = 0;
        hold_used   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_arm && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                drive_stall <= 1'b1;
            end
            else
                drive_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic read_all_regs;
        begin
            cfg_access(1'b0, REG_P_GAIN, '0);
            cfg_access(1'b0, REG_I_GAIN, '0);
            cfg_access(1'b0, REG_D_GAIN, '0);
            cfg_access(1'b0, REG_RAMP_RATE, '0);
            cfg_access(1'b0, REG_OUTPUT_LIMIT, '0);
        end
    endtask

    task automatic write_gains(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                               input logic [31:0] ramp, input logic [31:0] lim);
        begin
            cfg_access(1'b1, REG_P_GAIN, p);
            cfg_access(1'b1, REG_I_GAIN, i);
            cfg_access(1'b1, REG_D_GAIN, d);
            cfg_access(1'b1, REG_RAMP_RATE, ramp);
            cfg_access(1'b1, REG_OUTPUT_LIMIT, lim);
            read_all_regs();
        end
    endtask

    // Called and returning at a falling edge.
    task automatic send_req(input logic c, input logic [31:0] ev, input logic [19:0] t);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
            req_valid   <= 1'b1;
            cmd         <= c;
            error_value <= ev;
            elapsed_us  <= t;
            do @(posedge clk); while (req_stall);
            @(negedge clk);
        end
    endtask

    task automatic drain_results;
        begin
            req_valid <= 1'b0;
            do @(negedge clk); while (pending != 0);
        end
    endtask

    function automatic logic [31:0] rand_gain;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0:       return '0;
            3:       return r;
            default: return {{11{r[20]}}, r[20:0]};
        endcase
    endfunction

    function automatic logic [31:0] rand_ramp;
        case ($urandom_range(3))
            0:       return '0;
            3:       return $urandom;
            default: return $urandom_range(32'h00FF_FFFF, 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_limit;
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return '0;
            2:       return $urandom;
            default: return $urandom_range(32'h0040_0000, 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_error;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [19:0] rand_elapsed;
        case ($urandom_range(11))
            0:       return '0;
            1:       return 20'($urandom_range(20'hFFFFF, 500001));
            2:       return 20'd500000;
            3:       return 20'd1;
            4, 5:    return 20'($urandom_range(500000, 1));
            default: return 20'($urandom_range(5000, 100));
        endcase
    endfunction

    initial
    begin
        int ph;
        int n;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 1'b0;
        cmd         = 1'b0;
        error_value = '0;
        elapsed_us  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_arm    = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        read_all_regs();
        // A write past the last register must leave everything untouched.
        cfg_access(1'b1, 3'd5, 32'hFFFF_FFFF);
        read_all_regs();

        write_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0020, 32'h0, 32'h7FFF_FFFF);
        send_req(1'b0, 32'h7FFF_FFFF, 20'd1000);
        send_req(1'b0, 32'h8000_0000, 20'd0);
        send_req(1'b0, 32'h0001_2345, 20'd500000);
        send_req(1'b0, 32'hFFFF_FFFB, 20'd500001);
        send_req(1'b0, 32'h0001_0000, 20'd1);
        send_req(1'b0, 32'h0000_0000, 20'hFFFFF);
        send_req(1'b1, 32'hFFFF_FFFF, 20'hFFFFF);
        send_req(1'b0, 32'h0003_0000, 20'd1000);
        send_req(1'b1, 32'h0000_0000, 20'd0);

        drain_results();
        write_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(1'b0, 32'h7FFF_FFFF, 20'd1);
        send_req(1'b0, 32'h8000_0000, 20'd1);
        send_req(1'b0, 32'h8000_0000, 20'd500000);

        drain_results();
        write_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        send_req(1'b0, 32'h7FFF_FFFF, 20'd250);
        send_req(1'b0, 32'h8000_0000, 20'd0);

        drain_results();
        write_gains(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF);
        send_req(1'b1, 32'h0, 20'd0);
        send_req(1'b0, 32'h0010_0000, 20'd1000);
        send_req(1'b0, 32'hFFF0_0000, 20'd500000);
        send_req(1'b0, 32'h0010_0000, 20'd500000);

        // Lowering the limit under a ramp must clamp the held output again.
        drain_results();
        cfg_access(1'b1, REG_OUTPUT_LIMIT, 32'h0000_0100);
        send_req(1'b0, 32'h0010_0000, 20'd1000);
        send_req(1'b0, 32'hFFF0_0000, 20'd1000);

        for (ph = 0; ph < 8; ph++)
        begin
            drain_results();
            write_gains(rand_gain(), rand_gain(), rand_gain(), rand_ramp(), rand_limit());
            idle_pct  = (ph % 4 == 1) ? 82 : ((ph % 4 == 3) ? 7 : 0);
            stall_pct <= (ph % 4 == 2) ? 82 : ((ph % 4 == 3) ? 7 : 0);
            for (n = 0; n < 104; n++)
            begin
                if (ph == 2 && n == 30)
                    hold_arm <= 1'b1;
                if (ph == 1 && n == 50)
                    drain_results();
                send_req($urandom_range(99) < 8, rand_error(), rand_elapsed());
            end
        end

        drain_results();
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
